// ===== design/qtnl_pkg.sv =====
// ============================================================================
// qtnl_pkg
// Shared constants, register codes and types of the quantised target norm
// loss block.
// ============================================================================
package qtnl_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int FRAC_BITS   = 12;
   localparam int MAG_W       = SAMPLE_W;
   localparam int TERM_W      = 2 * MAG_W;
   localparam int ACC_W       = 56;
   localparam int LOSS_W      = 48;
   localparam int SCALE_W     = 16;
   localparam int PART_W      = ACC_W / 2;
   localparam int PROD_W      = PART_W + SCALE_W;
   localparam int FULL_W      = ACC_W + SCALE_W;
   localparam int THR_COUNT   = 7;
   localparam int LVL_COUNT   = 8;
   localparam int LVL_IDX_W   = $clog2(LVL_COUNT);
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   localparam logic signed [SAMPLE_W-1:0] ONE_Q       = SAMPLE_W'(1 << FRAC_BITS);
   localparam logic [SCALE_W-1:0]         SCALE_RESET = SCALE_W'(32768);
   localparam logic [ACC_W-1:0]           ACC_MAX     = '1;
   localparam logic [LOSS_W-1:0]          LOSS_MAX    = '1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_METHOD   = 3'd0,
      CSR_NORM     = 3'd1,
      CSR_FIXED    = 3'd2,
      CSR_THR_LOW  = 3'd3,
      CSR_THR_HIGH = 3'd4,
      CSR_LVL_LOW  = 3'd5,
      CSR_LVL_HIGH = 3'd6,
      CSR_SCALE    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      METHOD_FIXED = 2'd0,
      METHOD_TWO   = 2'd1,
      METHOD_FOUR  = 2'd2,
      METHOD_EIGHT = 2'd3
   } method_type;

   typedef enum logic {
      NORM_L2 = 1'b0,
      NORM_L1 = 1'b1
   } norm_type;

   typedef struct packed {
      method_type                            method;
      norm_type                              norm;
      logic signed [SAMPLE_W-1:0]            fixed_target;
      logic [THR_COUNT-1:0][SAMPLE_W-1:0]    thresholds;
      logic [LVL_COUNT-1:0][SAMPLE_W-1:0]    levels;
      logic [SCALE_W-1:0]                    scale;
   } cfg_type;

   typedef struct packed {
      logic             last;
      logic [MAG_W-1:0] mag;
   } item_type;

endpackage

// ===== design/qtnl_front.sv =====
// ============================================================================
// qtnl_front
// Picks the target of each sample and registers the magnitude of the
// difference together with the end-of-set mark.
// ============================================================================
module qtnl_front import qtnl_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       push_valid,
   input  logic                       push_ready,
   output item_type                   push_item
);

   logic                       valid_ff, valid_in;
   item_type                   item_ff, item_in;
   logic [THR_COUNT-1:0]       below;
   logic [THR_COUNT-1:0]       lower_ok;
   logic [LVL_IDX_W-1:0]       top_idx;
   logic signed [SAMPLE_W-1:0] target;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [SAMPLE_W:0]   neg_diff;
   logic [MAG_W-1:0]           mag;

   always_comb begin
      for (int k = 0; k < THR_COUNT; k++) begin
         below[k] = req_sample < signed'(cfg.thresholds[k]);
      end
      lower_ok = {~below[THR_COUNT-2:0], 1'b1};
      case (cfg.method)
         METHOD_TWO:  top_idx = LVL_IDX_W'(0);
         METHOD_FOUR: top_idx = LVL_IDX_W'(2);
         default:     top_idx = LVL_IDX_W'(THR_COUNT - 1);
      endcase
      if (!below[top_idx] && req_sample <= ONE_Q) begin
         target = signed'(cfg.levels[top_idx + LVL_IDX_W'(1)]);
      end else begin
         target = ONE_Q;
      end
      for (int k = THR_COUNT - 1; k >= 0; k--) begin
         if (k <= int'(top_idx) && below[k] && lower_ok[k]) begin
            target = signed'(cfg.levels[k]);
         end
      end
      if (req_sample[SAMPLE_W-1]) begin
         target = '0;
      end
      if (cfg.method == METHOD_FIXED) begin
         target = cfg.fixed_target;
      end
      diff     = {req_sample[SAMPLE_W-1], req_sample} - {target[SAMPLE_W-1], target};
      neg_diff = -diff;
      mag      = diff[SAMPLE_W] ? neg_diff[MAG_W-1:0] : diff[MAG_W-1:0];
   end

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in     = 1'b1;
         item_in.last = req_last;
         item_in.mag  = mag;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

// ===== design/qtnl_queue.sv =====
// ============================================================================
// qtnl_queue
// Short first-in first-out queue of classified samples between the front
// and the back.
// ============================================================================
module qtnl_queue import qtnl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  item_type               push_item,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output item_type               pop_item,
   output logic [QUEUE_CNT_W-1:0] count
);

   item_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign push_ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(do_push) - QUEUE_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/qtnl_back.sv =====
// ============================================================================
// qtnl_back
// Forms the error term, keeps the saturating sum and, at the end of a set,
// scales the sum through the partial-product and output stages into the result register.
// ============================================================================
module qtnl_back import qtnl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  item_type          pop_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [LOSS_W-1:0] rsp_loss_value,
   output logic              rsp_overflow
);

   logic                t_valid_ff, t_valid_in;
   logic                t_last_ff;
   logic [TERM_W-1:0]   t_term_ff, t_term_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic                sat_ff, sat_in;
   logic                s_valid_ff, s_valid_in;
   logic [ACC_W-1:0]    s_sum_ff;
   logic                s_sat_ff;
   logic                p_valid_ff, p_valid_in;
   logic [PROD_W-1:0]   p_hi_ff, p_lo_ff;
   logic                p_sat_ff;
   logic                o_valid_ff, o_valid_in;
   logic [LOSS_W-1:0]   o_loss_ff, o_loss_in;
   logic                o_ovf_ff, o_ovf_in;

   logic                o_load, p_load, s_free, t_take, t_load;
   logic [ACC_W:0]      acc_sum;
   logic [ACC_W-1:0]    acc_new;
   logic                sat_new;
   logic [FULL_W-1:0]   full;
   logic [ACC_W-1:0]    scaled;
   logic                over;

   assign o_load    = p_valid_ff && (!o_valid_ff || rsp_ready);
   assign p_load    = s_valid_ff && (!p_valid_ff || o_load);
   assign s_free    = !s_valid_ff || p_load;
   assign t_take    = t_valid_ff && (!t_last_ff || s_free);
   assign pop_ready = !t_valid_ff || t_take;
   assign t_load    = pop_valid && pop_ready;

   always_comb begin
      if (cfg.norm == NORM_L1) begin
         t_term_in = TERM_W'(pop_item.mag);
      end else begin
         t_term_in = TERM_W'(pop_item.mag) * TERM_W'(pop_item.mag);
      end
      t_valid_in = t_load ? 1'b1 : (t_take ? 1'b0 : t_valid_ff);
   end

   always_comb begin
      acc_sum = {1'b0, acc_ff} + (ACC_W + 1)'(t_term_ff);
      acc_new = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
      sat_new = sat_ff || acc_sum[ACC_W];
      acc_in  = acc_ff;
      sat_in  = sat_ff;
      if (t_take) begin
         if (t_last_ff) begin
            acc_in = '0;
            sat_in = 1'b0;
         end else begin
            acc_in = acc_new;
            sat_in = sat_new;
         end
      end
      s_valid_in = (t_take && t_last_ff) ? 1'b1 : (p_load ? 1'b0 : s_valid_ff);
      p_valid_in = p_load ? 1'b1 : (o_load ? 1'b0 : p_valid_ff);
   end

   always_comb begin
      full       = {p_hi_ff, PART_W'(0)} + FULL_W'(p_lo_ff);
      scaled     = full[FULL_W-1:SCALE_W];
      over       = |scaled[ACC_W-1:LOSS_W];
      o_loss_in  = over ? LOSS_MAX : scaled[LOSS_W-1:0];
      o_ovf_in   = p_sat_ff || over;
      o_valid_in = o_load ? 1'b1 : (rsp_ready ? 1'b0 : o_valid_ff);
   end

   assign rsp_valid      = o_valid_ff;
   assign rsp_loss_value = o_loss_ff;
   assign rsp_overflow   = o_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         acc_ff     <= '0;
         sat_ff     <= 1'b0;
      end else begin
         t_valid_ff <= t_valid_in;
         s_valid_ff <= s_valid_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
         acc_ff     <= acc_in;
         sat_ff     <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (t_load) begin
         t_last_ff <= pop_item.last;
         t_term_ff <= t_term_in;
      end
      if (t_take && t_last_ff) begin
         s_sum_ff <= acc_new;
         s_sat_ff <= sat_new;
      end
      if (p_load) begin
         p_lo_ff  <= PROD_W'(s_sum_ff[PART_W-1:0]) * PROD_W'(cfg.scale);
         p_hi_ff  <= PROD_W'(s_sum_ff[ACC_W-1:PART_W]) * PROD_W'(cfg.scale);
         p_sat_ff <= s_sat_ff;
      end
      if (o_load) begin
         o_loss_ff <= o_loss_in;
         o_ovf_ff  <= o_ovf_in;
      end
   end

endmodule

// ===== design/quantized_target_norm_loss.sv =====
// A last sample's result passes the front, queue, term, sum, product and output stages.
// One sample per cycle when not stalled, set by the single front stage and accumulator add.
// The product stage scales a result; up to two finished sets may wait behind the output.
// Reset clears the sum, the flag, all stages and the queue, and restores register defaults.
// ============================================================================
// quantized_target_norm_loss
// Accumulates the squared or absolute distance between each sample and its
// quantised or fixed target and reports the scaled sum at the end of every set.
// ============================================================================
module quantized_target_norm_loss import qtnl_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [LOSS_W-1:0]          rsp_loss_value,
   output logic                       rsp_overflow
);

   cfg_type                cfg_ff, cfg_in;
   logic                   q_push_valid, q_push_ready;
   item_type               q_push_item;
   logic                   q_pop_valid, q_pop_ready;
   item_type               q_pop_item;
   logic [QUEUE_CNT_W-1:0] q_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_METHOD:   cfg_in.method = method_type'(csr_wdata[1:0]);
            CSR_NORM:     cfg_in.norm = norm_type'(csr_wdata[0]);
            CSR_FIXED:    cfg_in.fixed_target = signed'(csr_wdata[SAMPLE_W-1:0]);
            CSR_THR_LOW:  cfg_in.thresholds[3:0] = csr_wdata;
            CSR_THR_HIGH: cfg_in.thresholds[6:4] = csr_wdata[3*SAMPLE_W-1:0];
            CSR_LVL_LOW:  cfg_in.levels[3:0] = csr_wdata;
            CSR_LVL_HIGH: cfg_in.levels[7:4] = csr_wdata;
            CSR_SCALE:    cfg_in.scale = csr_wdata[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{method: METHOD_FIXED, norm: NORM_L2, fixed_target: '0,
                     thresholds: '0, levels: '0, scale: SCALE_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   qtnl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .req_last   (req_last),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_item  (q_push_item)
   );

   qtnl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_item  (q_push_item),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_item   (q_pop_item),
      .count      (q_count)
   );

   qtnl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .pop_valid      (q_pop_valid),
      .pop_ready      (q_pop_ready),
      .pop_item       (q_pop_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_loss_value (rsp_loss_value),
      .rsp_overflow   (rsp_overflow)
   );

`ifndef NO_ASSERTIONS
   a_no_result_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result offered directly after reset.");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("Queue occupancy beyond its depth.");

   a_queue_push_counts: assert property (@(posedge clock) disable iff (reset)
      (q_push_valid && q_push_ready && !(q_pop_valid && q_pop_ready))
      |=> q_count == $past(q_count) + QUEUE_CNT_W'(1))
      else $error("Queue transfer in not counted.");

   a_queue_pop_counts: assert property (@(posedge clock) disable iff (reset)
      (q_pop_valid && q_pop_ready && !(q_push_valid && q_push_ready))
      |=> q_count + QUEUE_CNT_W'(1) == $past(q_count))
      else $error("Queue transfer out not counted.");
`endif

endmodule
